@@ rtl/smp_pkg.sv @@
// Package for the STUN message parser: types and constants.
// No dependencies; used by every module of the block.
`default_nettype none
package smp_pkg;
  localparam logic [15:0] TypeBindReq = 16'h0001;
  localparam logic [15:0] AttrMapped  = 16'h0001;
  localparam logic [15:0] AttrUser    = 16'h0006;
  localparam logic [15:0] AttrPass    = 16'h0007;
  localparam logic [15:0] MappedLen   = 16'd8;
  localparam logic [16:0] CountMax    = 17'h1FFFF;

  typedef enum logic [1:0] {
    VerdictRunt      = 2'd0,
    VerdictMalformed = 2'd1,
    VerdictIgnored   = 2'd2,
    VerdictAccepted  = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [16:0] pos;
  } byte_item_t;
endpackage
`default_nettype wire

@@ rtl/smp_front.sv @@
// Front end: accepts payload bytes and tags each with its saturating position.
// Depends on smp_pkg.
`default_nettype none
module smp_front import smp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] payload_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       valid_i,
  output logic            ready_o,
  output byte_item_t      item_o,
  output logic            item_valid_o,
  input  wire logic       item_ready_i
);
  logic [16:0] cnt_q, cnt_d;
  logic        acc;

  assign ready_o      = item_ready_i;
  assign acc          = valid_i && item_ready_i;
  assign item_valid_o = valid_i;
  assign item_o       = '{data: payload_byte_i, last: last_byte_i, pos: cnt_q};

  always_comb begin
    cnt_d = cnt_q;
    if (acc) begin
      if (last_byte_i) cnt_d = '0;
      else if (cnt_q != CountMax) cnt_d = cnt_q + 17'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
endmodule
`default_nettype wire

@@ rtl/smp_queue.sv @@
// Two-entry queue between front and back ends.
// Depends on smp_pkg.
`default_nettype none
module smp_queue import smp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  byte_item_t in_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output byte_item_t out_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i
);
  byte_item_t  mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_o       = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ rtl/smp_back.sv @@
// Back end: header capture, attribute walk and verdict into an output register.
// Depends on smp_pkg.
`default_nettype none
module smp_back import smp_pkg::*; #(
  parameter int HeaderBytes = 20
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  byte_item_t  item_i,
  input  wire logic   item_valid_i,
  output logic        item_ready_o,
  output logic        valid_o,
  input  wire logic   ready_i,
  output logic [1:0]  verdict_o,
  output logic        length_scrambled_o,
  output logic [15:0] message_type_o,
  output logic [63:0] txn_id_high_o,
  output logic [63:0] txn_id_low_o,
  output logic        mapped_found_o,
  output logic [15:0] mapped_port_o,
  output logic [31:0] mapped_ip_o,
  output logic [16:0] user_offset_o,
  output logic [15:0] user_length_o,
  output logic [16:0] pass_offset_o,
  output logic [15:0] pass_length_o
);
  localparam logic [16:0] HdrB = 17'(HeaderBytes);

  logic [15:0] htype_q, htype_d, hlen_q, hlen_d;
  logic [63:0] tx0_q, tx0_d, tx1_q, tx1_d, addr_q, addr_d;
  logic        phase_q, phase_d, stop_q, stop_d;
  logic [31:0] ahdr_q, ahdr_d;
  logic [15:0] arem_q, arem_d;
  logic [16:0] used_q, used_d;
  logic [2:0]  hgot_q, hgot_d;
  logic        mf_q, mf_d;
  logic [15:0] mp_q, mp_d, ul_q, ul_d, pl_q, pl_d;
  logic [31:0] mi_q, mi_d;
  logic [16:0] uo_q, uo_d, po_q, po_d;
  logic        ov_q;
  logic        acc;
  logic [7:0]  b;
  logic [16:0] pos, cnt, rr, lim;
  logic [31:0] sh;
  logic [15:0] vl;
  logic        fin, scr;
  logic [1:0]  verd;

  assign item_ready_o = !ov_q || ready_i;
  assign acc = item_valid_i && item_ready_o;
  assign b   = item_i.data;
  assign pos = item_i.pos;
  assign cnt = (pos == CountMax) ? pos : pos + 17'd1;

  always_comb begin
    htype_d = htype_q; hlen_d = hlen_q; tx0_d = tx0_q; tx1_d = tx1_q;
    addr_d = addr_q; phase_d = phase_q; stop_d = stop_q; ahdr_d = ahdr_q;
    arem_d = arem_q; used_d = used_q; hgot_d = hgot_q; mf_d = mf_q; mp_d = mp_q;
    mi_d = mi_q; uo_d = uo_q; ul_d = ul_q; po_d = po_q; pl_d = pl_q;
    fin = 1'b0;
    sh = ahdr_q; vl = ahdr_q[15:0];
    if (pos < 17'd2) htype_d = {htype_q[7:0], b};
    else if (pos < 17'd4) hlen_d = {hlen_q[7:0], b};
    else if (pos < 17'd12) tx0_d = {tx0_q[55:0], b};
    else if (pos < HdrB) tx1_d = {tx1_q[55:0], b};
    else if (!stop_q && (pos - HdrB) < {1'b0, hlen_q}) begin
      if (!phase_q) begin
        sh = {ahdr_q[23:0], b};
        vl = sh[15:0];
        ahdr_d = sh;
        hgot_d = hgot_q + 3'd1;
        if (hgot_q == 3'd3) begin
          if ({1'b0, used_q} + 18'd4 + {2'b0, vl} > {2'b0, hlen_q}) stop_d = 1'b1;
          else if (vl == 16'd0) begin addr_d = '0; fin = 1'b1; end
          else begin phase_d = 1'b1; arem_d = vl; addr_d = '0; end
        end
      end else begin
        addr_d = {addr_q[55:0], b};
        arem_d = arem_q - 16'd1;
        if (arem_q == 16'd1) fin = 1'b1;
      end
    end
    if (fin) begin
      // retire the attribute just completed
      if (sh[31:16] == AttrMapped && vl == MappedLen) begin
        mf_d = 1'b1; mp_d = addr_d[47:32]; mi_d = addr_d[31:0];
      end else if (sh[31:16] == AttrUser) begin
        uo_d = HdrB + used_q + 17'd4; ul_d = vl;
      end else if (sh[31:16] == AttrPass) begin
        po_d = HdrB + used_q + 17'd4; pl_d = vl;
      end
      used_d = used_q + 17'd4 + {1'b0, vl};
      phase_d = 1'b0; hgot_d = '0; ahdr_d = '0; addr_d = '0; arem_d = '0;
    end
  end

  assign rr   = cnt - HdrB;
  assign scr  = {1'b0, hlen_d} > rr;
  assign lim  = scr ? rr : {1'b0, hlen_d};
  assign verd = (used_d != lim) ? VerdictMalformed :
                (htype_d == TypeBindReq) ? VerdictAccepted : VerdictIgnored;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      htype_q <= '0; hlen_q <= '0; tx0_q <= '0; tx1_q <= '0; addr_q <= '0;
      phase_q <= 1'b0; stop_q <= 1'b0; ahdr_q <= '0; arem_q <= '0; used_q <= '0;
      hgot_q <= '0; mf_q <= 1'b0; mp_q <= '0; mi_q <= '0; uo_q <= '0; ul_q <= '0;
      po_q <= '0; pl_q <= '0; ov_q <= 1'b0;
    end else begin
      if (ov_q && ready_i) ov_q <= 1'b0;
      if (acc) begin
        if (item_i.last) begin
          htype_q <= '0; hlen_q <= '0; tx0_q <= '0; tx1_q <= '0; addr_q <= '0;
          phase_q <= 1'b0; stop_q <= 1'b0; ahdr_q <= '0; arem_q <= '0;
          used_q <= '0; hgot_q <= '0; mf_q <= 1'b0; mp_q <= '0; mi_q <= '0;
          uo_q <= '0; ul_q <= '0; po_q <= '0; pl_q <= '0;
          ov_q <= 1'b1;
        end else begin
          htype_q <= htype_d; hlen_q <= hlen_d; tx0_q <= tx0_d; tx1_q <= tx1_d;
          addr_q <= addr_d; phase_q <= phase_d; stop_q <= stop_d;
          ahdr_q <= ahdr_d; arem_q <= arem_d; used_q <= used_d;
          hgot_q <= hgot_d; mf_q <= mf_d; mp_q <= mp_d; mi_q <= mi_d;
          uo_q <= uo_d; ul_q <= ul_d; po_q <= po_d; pl_q <= pl_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && item_i.last) begin
      if (cnt < HdrB) begin
        verdict_o <= VerdictRunt; length_scrambled_o <= 1'b0;
        message_type_o <= '0; txn_id_high_o <= '0; txn_id_low_o <= '0;
        mapped_found_o <= 1'b0; mapped_port_o <= '0; mapped_ip_o <= '0;
        user_offset_o <= '0; user_length_o <= '0;
        pass_offset_o <= '0; pass_length_o <= '0;
      end else begin
        verdict_o <= verd; length_scrambled_o <= scr;
        message_type_o <= htype_d; txn_id_high_o <= tx0_d; txn_id_low_o <= tx1_d;
        mapped_found_o <= mf_d; mapped_port_o <= mp_d; mapped_ip_o <= mi_d;
        user_offset_o <= uo_d; user_length_o <= ul_d;
        pass_offset_o <= po_d; pass_length_o <= pl_d;
      end
    end
  end

  assign valid_o = ov_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !ready_i |=> ov_q) else $error("result dropped");
  a_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> arem_q != 16'd0) else $error("value phase with no bytes left");
  a_hgot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hgot_q <= 3'd4) else $error("attribute header count overflow");
endmodule
`default_nettype wire

@@ rtl/stun_message_parser_core.sv @@
// STUN message parser top level: front end, queue and back end.
// Depends on smp_pkg, smp_front, smp_queue, smp_back.
//
// Usage: payload bytes enter on valid_i/ready_o, one per cycle while ready_o
// is high, with last_byte_i set on the final byte. One result per packet
// leaves on valid_o/ready_i, registered, in the cycle after the last byte is
// taken by the back end; bytes from the port pass through the queue first.
// Throughput: one byte per cycle unless the receiver stalls a waiting result,
// as the back end walks attributes byte by byte. The two-entry queue lets the
// front keep taking bytes while a result waits; when the receiver stalls,
// the queue fills and ready_o drops until the result is taken.
// Reset clears the byte counter, all parser state and the output valid.
// Packets shorter than the header give verdict runt with zero fields.
`default_nettype none
module stun_message_parser_core import smp_pkg::*; #(
  parameter int HeaderBytes = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [7:0]  payload_byte_i,
  input  wire logic        last_byte_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [1:0]       verdict_o,
  output logic             length_scrambled_o,
  output logic [15:0]      message_type_o,
  output logic [63:0]      txn_id_high_o,
  output logic [63:0]      txn_id_low_o,
  output logic             mapped_found_o,
  output logic [15:0]      mapped_port_o,
  output logic [31:0]      mapped_ip_o,
  output logic [16:0]      user_offset_o,
  output logic [15:0]      user_length_o,
  output logic [16:0]      pass_offset_o,
  output logic [15:0]      pass_length_o
);
  byte_item_t f_item, q_item;
  logic f_valid, f_ready, q_valid, q_ready;

  smp_front u_front (
    .clk_i, .rst_ni, .payload_byte_i, .last_byte_i, .valid_i, .ready_o,
    .item_o(f_item), .item_valid_o(f_valid), .item_ready_i(f_ready)
  );

  smp_queue u_queue (
    .clk_i, .rst_ni, .in_i(f_item), .in_valid_i(f_valid), .in_ready_o(f_ready),
    .out_o(q_item), .out_valid_o(q_valid), .out_ready_i(q_ready)
  );

  smp_back #(.HeaderBytes(HeaderBytes)) u_back (
    .clk_i, .rst_ni, .item_i(q_item), .item_valid_i(q_valid),
    .item_ready_o(q_ready), .valid_o, .ready_i, .verdict_o, .length_scrambled_o,
    .message_type_o, .txn_id_high_o, .txn_id_low_o, .mapped_found_o,
    .mapped_port_o, .mapped_ip_o, .user_offset_o, .user_length_o,
    .pass_offset_o, .pass_length_o
  );
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for stun_message_parser_core: streams STUN payloads
// byte by byte and checks every verdict against an in-bench parser model.
// Depends on smp_pkg and the stun_message_parser_core RTL.
`default_nettype none
module testbench;
  import smp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HdrBytes   = 20;
  localparam int AttrHdr    = 4;
  localparam int StallLimit = 2000;
  localparam int DrainWait  = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  typedef struct packed {
    verdict_e    verdict;
    logic        scrambled;
    logic [15:0] msg_type;
    logic [63:0] txn_high;
    logic [63:0] txn_low;
    logic        map_found;
    logic [15:0] map_port;
    logic [31:0] map_ip;
    logic [16:0] usr_off;
    logic [15:0] usr_len;
    logic [16:0] pwd_off;
    logic [15:0] pwd_len;
  } verdict_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic [7:0] payload_byte_i = '0;
  logic last_byte_i = 1'b0;
  logic ready_i = 1'b0;
  logic ready_o, valid_o;
  logic [1:0] verdict_o;
  logic length_scrambled_o, mapped_found_o;
  logic [15:0] message_type_o, mapped_port_o, user_length_o, pass_length_o;
  logic [63:0] txn_id_high_o, txn_id_low_o;
  logic [31:0] mapped_ip_o;
  logic [16:0] user_offset_o, pass_offset_o;

  stream_byte_t byte_fifo[$];
  verdict_rec_t verdict_fifo[$];
  logic [7:0]   pkt[$];
  logic [7:0]   attrs[$];
  int  errors = 0;
  bit  calm = 1'b0;
  bit  paused = 1'b0;
  int  send_idle = 0;
  int  recv_idle = 0;
  int  quiet_cycles = 0;

  // parser model state
  int unsigned byte_count, walk_used, hdr_got;
  logic [15:0] hdr_type, hdr_len, attr_left;
  logic [63:0] txn_hi, txn_lo, addr_shift;
  logic [31:0] attr_hdr;
  logic        in_value, walk_stopped;
  verdict_rec_t found;

  always #5 clk_i = ~clk_i;

  stun_message_parser_core i_dut (
    .clk_i, .rst_ni, .valid_i, .ready_o, .payload_byte_i, .last_byte_i,
    .valid_o, .ready_i, .verdict_o, .length_scrambled_o, .message_type_o,
    .txn_id_high_o, .txn_id_low_o, .mapped_found_o, .mapped_port_o,
    .mapped_ip_o, .user_offset_o, .user_length_o, .pass_offset_o,
    .pass_length_o
  );

  function automatic void clear_parser();
    byte_count = 0; walk_used = 0; hdr_got = 0;
    hdr_type = '0; hdr_len = '0; attr_left = '0;
    txn_hi = '0; txn_lo = '0; addr_shift = '0; attr_hdr = '0;
    in_value = 1'b0; walk_stopped = 1'b0;
    found = '0;
  endfunction

  function automatic void close_attr();
    logic [15:0] atype, vlen;
    int unsigned voff;
    atype = attr_hdr[31:16];
    vlen  = attr_hdr[15:0];
    voff  = HdrBytes + walk_used + AttrHdr;
    if (atype == AttrMapped && vlen == MappedLen) begin
      found.map_found = 1'b1;
      found.map_port  = addr_shift[47:32];
      found.map_ip    = addr_shift[31:0];
    end else if (atype == AttrUser) begin
      found.usr_off = voff[16:0];
      found.usr_len = vlen;
    end else if (atype == AttrPass) begin
      found.pwd_off = voff[16:0];
      found.pwd_len = vlen;
    end
    walk_used += AttrHdr + vlen;
    in_value = 1'b0; hdr_got = 0; attr_hdr = '0; addr_shift = '0; attr_left = '0;
  endfunction

  function automatic void walk_byte(logic [7:0] b);
    if (!in_value) begin
      attr_hdr = {attr_hdr[23:0], b};
      hdr_got++;
      if (hdr_got >= AttrHdr) begin
        if (walk_used + AttrHdr + attr_hdr[15:0] > hdr_len) walk_stopped = 1'b1;
        else if (attr_hdr[15:0] == 0) close_attr();
        else begin
          in_value = 1'b1;
          attr_left = attr_hdr[15:0];
          addr_shift = '0;
        end
      end
    end else begin
      addr_shift = {addr_shift[55:0], b};
      attr_left = attr_left - 16'd1;
      if (attr_left == 0) close_attr();
    end
  endfunction

  // advance the model by one accepted byte; queue a verdict on the last byte
  function automatic void parse_byte(logic [7:0] b, logic last);
    verdict_rec_t rec;
    int unsigned rx, lim;
    if (byte_count < 2) hdr_type = {hdr_type[7:0], b};
    else if (byte_count < 4) hdr_len = {hdr_len[7:0], b};
    else if (byte_count < 12) txn_hi = {txn_hi[55:0], b};
    else if (byte_count < HdrBytes) txn_lo = {txn_lo[55:0], b};
    else if (!walk_stopped && byte_count - HdrBytes < hdr_len) walk_byte(b);
    if (byte_count < CountMax) byte_count++;
    if (!last) return;
    rec = '0;
    if (byte_count >= HdrBytes) begin
      rec = found;
      rx = byte_count - HdrBytes;
      rec.scrambled = hdr_len > rx;
      lim = rec.scrambled ? rx : hdr_len;
      if (walk_used != lim) rec.verdict = VerdictMalformed;
      else if (hdr_type == TypeBindReq) rec.verdict = VerdictAccepted;
      else rec.verdict = VerdictIgnored;
      rec.msg_type = hdr_type;
      rec.txn_high = txn_hi;
      rec.txn_low  = txn_lo;
    end
    verdict_fifo.push_back(rec);
    clear_parser();
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    stream_byte_t nxt;
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else begin
      if (valid_i && ready_o) parse_byte(payload_byte_i, last_byte_i);
      if (!valid_i || ready_o) begin
        if (send_idle > 0) begin
          send_idle--;
          valid_i <= 1'b0;
        end else if (byte_fifo.size() == 0) begin
          valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
          send_idle = $urandom_range(0, 11);
          valid_i <= 1'b0;
        end else begin
          nxt = byte_fifo.pop_front();
          valid_i <= 1'b1;
          payload_byte_i <= nxt.data;
          last_byte_i <= nxt.last;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_rec_t want;
    if (!rst_ni) begin
      ready_i <= 1'b0;
    end else begin
      if (valid_o && ready_i) begin
        if (verdict_fifo.size() == 0) begin
          errors++;
          $display("%0t: unexpected verdict %0d, nothing pending", $time, verdict_o);
        end else begin
          want = verdict_fifo.pop_front();
          check_field("verdict", want.verdict, verdict_o);
          check_field("length_scrambled", want.scrambled, length_scrambled_o);
          check_field("message_type", want.msg_type, message_type_o);
          check_field("txn_id_high", want.txn_high, txn_id_high_o);
          check_field("txn_id_low", want.txn_low, txn_id_low_o);
          check_field("mapped_found", want.map_found, mapped_found_o);
          check_field("mapped_port", want.map_port, mapped_port_o);
          check_field("mapped_ip", want.map_ip, mapped_ip_o);
          check_field("user_offset", want.usr_off, user_offset_o);
          check_field("user_length", want.usr_len, user_length_o);
          check_field("pass_offset", want.pwd_off, pass_offset_o);
          check_field("pass_length", want.pwd_len, pass_length_o);
        end
      end
      if (recv_idle > 0) begin
        recv_idle--;
        ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        recv_idle = $urandom_range(0, 11);
        ready_i <= 1'b0;
      end else begin
        ready_i <= 1'b1;
      end
    end
  end

  // watchdog: stop when neither side moves for too long
  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i) || !rst_ni) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void add_attr(logic [15:0] atype, int vlen, int body);
    attrs.push_back(atype[15:8]); attrs.push_back(atype[7:0]);
    attrs.push_back(vlen[15:8]);  attrs.push_back(vlen[7:0]);
    for (int i = 0; i < body; i++) attrs.push_back(8'($urandom));
  endfunction

  // header + collected attributes, then hand the bytes to the driver
  function automatic void send_packet(logic [15:0] mtype, logic [15:0] alen,
                                      int keep, int extra);
    pkt.delete();
    pkt.push_back(mtype[15:8]); pkt.push_back(mtype[7:0]);
    pkt.push_back(alen[15:8]);  pkt.push_back(alen[7:0]);
    for (int i = 0; i < 16; i++) pkt.push_back(8'($urandom));
    foreach (attrs[i]) pkt.push_back(attrs[i]);
    for (int i = 0; i < extra; i++) pkt.push_back(8'($urandom));
    if (keep > 0 && keep < pkt.size()) pkt = pkt[0:keep-1];
    foreach (pkt[i]) byte_fifo.push_back('{data: pkt[i], last: i == pkt.size() - 1});
    attrs.delete();
  endfunction

  function automatic void send_random_packet();
    int nattr, vlen, keep, extra, adj;
    logic [15:0] mtype;
    int pick;
    nattr = $urandom_range(0, 4);
    for (int a = 0; a < nattr; a++) begin
      pick = $urandom_range(0, 5);
      vlen = $urandom_range(0, 12);
      case (pick)
        0, 1: add_attr(AttrMapped, MappedLen, MappedLen);
        2: add_attr(AttrMapped, vlen, vlen);
        3: add_attr(AttrUser, vlen, vlen);
        4: add_attr(AttrPass, vlen, vlen);
        default: add_attr(16'($urandom), vlen, vlen);
      endcase
    end
    mtype = ($urandom_range(0, 2) != 0) ? TypeBindReq : 16'($urandom);
    adj = 0; keep = 0; extra = 0;
    case ($urandom_range(0, 9))
      0: adj = $urandom_range(1, 300);                 // advertise too much
      1: adj = -$urandom_range(1, 6);                  // advertise too little
      2: keep = $urandom_range(1, HdrBytes - 1);       // runt
      3: keep = HdrBytes + $urandom_range(0, attrs.size());
      4: extra = $urandom_range(1, 8);                 // trailing bytes
      5: begin
        for (int i = 0; i < $urandom_range(1, 3); i++) attrs.push_back(8'($urandom));
        adj = 0;
      end
      default: ;
    endcase
    send_packet(mtype, 16'(int'(attrs.size()) + adj < 0 ? 0 : attrs.size() + adj),
                keep, extra);
  endfunction

  initial begin
    clear_parser();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: runts, empty messages, each attribute kind, broken walks
    send_packet(TypeBindReq, 0, 1, 0);
    send_packet(TypeBindReq, 0, HdrBytes - 1, 0);
    send_packet(TypeBindReq, 0, 0, 0);
    send_packet(16'hFFFF, 0, 0, 0);
    add_attr(AttrMapped, MappedLen, MappedLen);
    add_attr(AttrMapped, 6, 6);
    add_attr(AttrUser, 5, 5);
    add_attr(AttrPass, 0, 0);
    send_packet(TypeBindReq, attrs.size(), 0, 0);
    add_attr(AttrPass, 3, 3);
    add_attr(AttrMapped, MappedLen, MappedLen);
    send_packet(16'h0101, attrs.size(), 0, 4);             // bytes past length
    add_attr(AttrUser, 40, 2);
    send_packet(TypeBindReq, 100, 0, 0);                   // scrambled length
    add_attr(AttrUser, 10, 10);
    send_packet(TypeBindReq, 8, 0, 0);                     // attribute overruns
    add_attr(AttrUser, 2, 2);
    attrs.push_back(8'h00); attrs.push_back(8'h07);
    send_packet(TypeBindReq, attrs.size(), 0, 0);          // partial attr header
    // longer packet: a wide username value followed by trailing bytes
    add_attr(AttrUser, 100, 100);
    send_packet(TypeBindReq, attrs.size(), 0, 30);

    for (int n = 0; n < 1400; n = n) begin
      if (n > 600 && !paused) begin
        // hold off until every verdict is back
        while (valid_i || byte_fifo.size() != 0 || verdict_fifo.size() != 0)
          @(posedge clk_i);
        paused = 1'b1;
      end
      if (n > 1100) calm = 1'b1;
      n += byte_fifo.size() == 0 ? 0 : 0;
      send_random_packet();
      n += pkt.size();
      while (byte_fifo.size() >= 64) @(posedge clk_i);
    end

    while (valid_i || byte_fifo.size() != 0 || verdict_fifo.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0 && verdict_fifo.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
